### src/tmp_pkg.sv
// Shared constants, codes and types of the trapezoidal motion profile unit.
`default_nettype none

package tmp_pkg;

	// Fixed-point formats.
	localparam int FRAC_BITS = 16;
	localparam int POS_WIDTH = 32;
	localparam int TIME_W = 48;
	localparam int DIST_W = POS_WIDTH + 1;
	localparam int VEL_W = 31;
	localparam int STEP_W = 20;
	localparam int PHASE_W = 2;

	// Stream and register port widths.
	localparam int IN_DATA_W = ((STEP_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((POS_WIDTH + PHASE_W + TIME_W + 7) / 8) * 8;
	localparam int ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Serial arithmetic: word widths and iteration counts.
	localparam int WORD_W = 64;
	localparam int ROOT_W = 32;
	localparam int DVSR_W = 32;
	localparam int CNT_W = 7;
	localparam int MUL_STEPS = WORD_W;
	localparam int DIV_STEPS = WORD_W;
	localparam int SQRT_STEPS = ROOT_W;

	typedef enum logic [PHASE_W-1:0] {
		PH_ACCEL,
		PH_CRUISE,
		PH_DECEL,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		REG_START,
		REG_TARGET,
		REG_VEL,
		REG_ACCEL
	} reg_idx_t;

	typedef enum logic [1:0] {
		ENG_NONE,
		ENG_MUL,
		ENG_DIV,
		ENG_SQRT
	} eng_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_DA,
		ST_MUL_VV,
		ST_DIV_T1,
		ST_DIV_CRUISE,
		ST_DIV_X1,
		ST_SQRT,
		ST_DIV_T1_TRI,
		ST_ADVANCE,
		ST_CLASSIFY,
		ST_MUL_GAIN,
		ST_MUL_A1,
		ST_MUL_A2,
		ST_POSN
	} state_t;

endpackage

`default_nettype wire

### src/trapezoid_motion_profile_unit.sv
// Top level of the trapezoidal motion profile unit: sequencer and serial arithmetic.
`default_nettype none

// Point-to-point set point generator with a trapezoidal (or, for short moves,
// triangular) velocity profile. Each request on the slave stream is one control
// tick: s_tuser carries the restart flag and s_tdata the time step. For each
// request exactly one result leaves on the master stream: position, phase and
// total profile time. Start, target, peak velocity and acceleration are written
// through the APB port. The user must write them only while the unit is idle;
// the unit itself does not enforce this.
// All multiplies, divides and the square root run through one shared bit-serial
// unit: a shift-add multiplier, a restoring divider and a digit-by-digit square
// root, one bit (two radicand bits for the root) per cycle. A finished tick needs
// no arithmetic, a cruising one a single multiply, an accelerating one two and a
// decelerating one three. A restart adds the segment computation, which differs
// for a trapezoid and a triangle.
// One request is worked at a time; the next is taken once the result has moved
// into the output register, so a stalled receiver only blocks after one more
// request has been computed. Reset clears the profile, so until the first
// restart the output is the start position, finished, with total time zero.

module trapezoid_motion_profile_unit (
	input  wire                                clk,
	input  wire                                arst_n,
	// Slave stream: tdata = tick_dt[19:0], zero filled; tuser = restart.
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [tmp_pkg::IN_DATA_W-1:0]      s_tdata,
	input  wire                                s_tuser,
	// Master stream: tdata = position[31:0], phase[33:32], total_time[81:34],
	// zero filled above.
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [tmp_pkg::OUT_DATA_W-1:0]     m_tdata,
	// Configuration port.
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire  [tmp_pkg::ADDR_W-1:0]         paddr,
	input  wire  [tmp_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [tmp_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);
	import tmp_pkg::*;

	localparam int GAIN_SH = FRAC_BITS;
	localparam int LOSS_SH = 2 * FRAC_BITS + 1;

	// Configuration registers.
	logic [POS_WIDTH-1:0] start_pos_q, target_pos_q;
	logic [VEL_W-1:0]     max_vel_q, accel_q;

	// Profile state.
	logic [TIME_W-1:0]    elapsed_q, t1_q, t2_q, tf_q;
	logic [DIST_W-1:0]    dist_q, x1_q, x2_q;
	logic                 dir_neg_q;
	logic [ROOT_W-1:0]    peak_q;

	// Sequencer.
	state_t               state_q, state_d;
	logic [CNT_W-1:0]     cnt_q, cnt_load;
	eng_t                 eng;
	logic                 cnt_done, out_free, out_load, trap_c;

	// Working registers of a tick.
	logic [STEP_W-1:0]    tstep_q;
	logic [WORD_W-1:0]    p1_q, p2_q, gain_q;
	logic [TIME_W-1:0]    cruise_q, t_op_q;
	logic [DIST_W-1:0]    x_q;
	phase_t               ph_q;

	// Serial engine registers.
	logic [WORD_W-1:0]    mcand_q, acc_h_q, acc_l_q;
	logic [WORD_W-1:0]    quo_q;
	logic [DVSR_W-1:0]    dvsr_q, rem_q;
	logic [WORD_W-1:0]    src_q;
	logic [ROOT_W:0]      srem_q;
	logic [ROOT_W-1:0]    root_q;

	// Output register.
	logic                 out_valid_q;
	logic [POS_WIDTH-1:0] out_pos_q;
	phase_t               out_ph_q;
	logic [TIME_W-1:0]    out_tt_q;

	// Combinational values.
	logic [VEL_W-1:0]     v_eff, a_eff;
	logic [DIST_W-1:0]    diff_c, dist_c;
	logic                 dir_c, cfg_wr;
	logic [WORD_W:0]      mul_sum;
	logic [2*WORD_W-1:0]  mul_prod;
	logic [DVSR_W:0]      div_sh;
	logic [DVSR_W+1:0]    div_diff;
	logic                 div_ge;
	logic [ROOT_W+2:0]    sq_r, sq_trial;
	logic [ROOT_W+3:0]    sq_diff;
	logic                 sq_ge;
	logic [TIME_W-1:0]    div_t48, tf_trap, tf_tri, adv_t;
	logic [TIME_W:0]      tf_sum, adv_sum;
	logic [WORD_W-1:0]    gain_m, a1_m, loss_m, dec_g, dist64;
	logic [DIST_W:0]      cr_sum, dec_sum;
	logic [DIST_W-1:0]    x_cruise, x_accel, x_decel;
	phase_t               cls_phase;
	logic [POS_WIDTH-1:0] pos_c;

	// ---------------------------------------------------------------
	// Configuration port.
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (reg_idx_t'(paddr[ADDR_W-1:2]))
			REG_START:  prdata = APB_DATA_W'(start_pos_q);
			REG_TARGET: prdata = APB_DATA_W'(target_pos_q);
			REG_VEL:    prdata = APB_DATA_W'(max_vel_q);
			REG_ACCEL:  prdata = APB_DATA_W'(accel_q);
			default:    prdata = '0;
		endcase
	end

	// A register value of zero counts as the smallest step.
	assign v_eff = (max_vel_q == '0) ? VEL_W'(1) : max_vel_q;
	assign a_eff = (accel_q == '0) ? VEL_W'(1) : accel_q;

	// Distance and direction of the move.
	assign diff_c = {target_pos_q[POS_WIDTH-1], target_pos_q}
		- {start_pos_q[POS_WIDTH-1], start_pos_q};
	assign dir_c  = diff_c[DIST_W-1];
	assign dist_c = dir_c ? (~diff_c + DIST_W'(1)) : diff_c;
	assign dist64 = WORD_W'(dist_q);

	// ---------------------------------------------------------------
	// Serial engine datapath.
	// ---------------------------------------------------------------
	assign mul_sum  = {1'b0, acc_h_q} + (acc_l_q[0] ? {1'b0, mcand_q} : '0);
	assign mul_prod = {acc_h_q, acc_l_q};

	assign div_sh   = {rem_q, quo_q[WORD_W-1]};
	assign div_diff = {1'b0, div_sh} - {2'b00, dvsr_q};
	assign div_ge   = !div_diff[DVSR_W+1];

	assign sq_r     = {srem_q, src_q[WORD_W-1 -: 2]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign sq_diff  = {1'b0, sq_r} - {1'b0, sq_trial};
	assign sq_ge    = !sq_diff[ROOT_W+3];

	// Saturated views of the finished product or quotient.
	assign div_t48 = (|quo_q[WORD_W-1:TIME_W]) ? '1 : quo_q[TIME_W-1:0];
	assign gain_m  = (|mul_prod[2*WORD_W-1:WORD_W+GAIN_SH]) ? '1
		: mul_prod[WORD_W+GAIN_SH-1:GAIN_SH];
	assign a1_m    = (|mul_prod[2*WORD_W-1:WORD_W]) ? '1 : mul_prod[WORD_W-1:0];
	assign loss_m  = (|mul_prod[2*WORD_W-1:WORD_W+LOSS_SH]) ? '1
		: mul_prod[WORD_W+LOSS_SH-1:LOSS_SH];

	// Segment end times.
	assign tf_sum  = {1'b0, t1_q} + {1'b0, cruise_q};
	assign tf_trap = tf_sum[TIME_W] ? '1 : tf_sum[TIME_W-1:0];
	assign tf_tri  = div_t48[TIME_W-1] ? '1 : {div_t48[TIME_W-2:0], 1'b0};

	// Time advance, saturating at the end of the profile.
	assign adv_sum = {1'b0, elapsed_q} + (TIME_W + 1)'(tstep_q);
	assign adv_t   = (adv_sum > {1'b0, tf_q}) ? tf_q : adv_sum[TIME_W-1:0];

	always_comb begin
		if (elapsed_q < t1_q) begin
			cls_phase = PH_ACCEL;
		end else if (elapsed_q < t2_q) begin
			cls_phase = PH_CRUISE;
		end else if (elapsed_q < tf_q) begin
			cls_phase = PH_DECEL;
		end else begin
			cls_phase = PH_DONE;
		end
	end

	// Travelled distance of each phase, clamped to the move.
	assign cr_sum   = {1'b0, gain_m[DIST_W-1:0]} + {1'b0, x1_q};
	assign x_cruise = (gain_m > dist64 || cr_sum > {1'b0, dist_q}) ? dist_q
		: cr_sum[DIST_W-1:0];
	assign x_accel  = (loss_m > dist64) ? dist_q : loss_m[DIST_W-1:0];
	assign dec_g    = (gain_q > loss_m) ? (gain_q - loss_m) : '0;
	assign dec_sum  = {1'b0, dec_g[DIST_W-1:0]} + {1'b0, x2_q};
	assign x_decel  = (dec_g > dist64 || dec_sum > {1'b0, dist_q}) ? dist_q
		: dec_sum[DIST_W-1:0];

	assign pos_c = dir_neg_q ? (start_pos_q - POS_WIDTH'(x_q))
		: (start_pos_q + POS_WIDTH'(x_q));

	assign trap_c = p1_q > mul_prod[WORD_W-1:0];

	// ---------------------------------------------------------------
	// Sequencer: next state.
	// ---------------------------------------------------------------
	assign cnt_done = (cnt_q == '0);
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = s_tuser ? ST_MUL_DA : ST_ADVANCE;
				end
			end
			ST_MUL_DA:     if (cnt_done) state_d = ST_MUL_VV;
			ST_MUL_VV: begin
				if (cnt_done) begin
					state_d = trap_c ? ST_DIV_T1 : ST_SQRT;
				end
			end
			ST_DIV_T1:     if (cnt_done) state_d = ST_DIV_CRUISE;
			ST_DIV_CRUISE: if (cnt_done) state_d = ST_DIV_X1;
			ST_DIV_X1:     if (cnt_done) state_d = ST_ADVANCE;
			ST_SQRT:       if (cnt_done) state_d = ST_DIV_T1_TRI;
			ST_DIV_T1_TRI: if (cnt_done) state_d = ST_ADVANCE;
			ST_ADVANCE:    state_d = ST_CLASSIFY;
			ST_CLASSIFY: begin
				case (cls_phase) inside
					PH_ACCEL:            state_d = ST_MUL_A1;
					PH_CRUISE, PH_DECEL: state_d = ST_MUL_GAIN;
					default:             state_d = ST_POSN;
				endcase
			end
			ST_MUL_GAIN: begin
				if (cnt_done) begin
					state_d = (ph_q == PH_CRUISE) ? ST_POSN : ST_MUL_A1;
				end
			end
			ST_MUL_A1:     if (cnt_done) state_d = ST_MUL_A2;
			ST_MUL_A2:     if (cnt_done) state_d = ST_POSN;
			ST_POSN:       if (out_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// Sequencer: outputs.
	// ---------------------------------------------------------------
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		out_load = (state_q == ST_POSN) && out_free;
		unique case (state_q) inside
			ST_MUL_DA, ST_MUL_VV, ST_MUL_GAIN, ST_MUL_A1, ST_MUL_A2:
				eng = ENG_MUL;
			ST_DIV_T1, ST_DIV_CRUISE, ST_DIV_X1, ST_DIV_T1_TRI:
				eng = ENG_DIV;
			ST_SQRT:
				eng = ENG_SQRT;
			default:
				eng = ENG_NONE;
		endcase
		cnt_load = '0;
		if (state_d != state_q) begin
			unique case (state_d) inside
				ST_MUL_DA, ST_MUL_VV, ST_MUL_GAIN, ST_MUL_A1, ST_MUL_A2:
					cnt_load = CNT_W'(MUL_STEPS);
				ST_DIV_T1, ST_DIV_CRUISE, ST_DIV_X1, ST_DIV_T1_TRI:
					cnt_load = CNT_W'(DIV_STEPS);
				ST_SQRT:
					cnt_load = CNT_W'(SQRT_STEPS);
				default:
					cnt_load = '0;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Control and profile state.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pos_q  <= '0;
			target_pos_q <= '0;
			max_vel_q    <= VEL_W'(1) << FRAC_BITS;
			accel_q      <= VEL_W'(1) << FRAC_BITS;
			elapsed_q    <= '0;
			dist_q       <= '0;
			dir_neg_q    <= 1'b0;
			t1_q         <= '0;
			t2_q         <= '0;
			tf_q         <= '0;
			x1_q         <= '0;
			x2_q         <= '0;
			peak_q       <= '0;
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_START:  start_pos_q  <= pwdata[POS_WIDTH-1:0];
					REG_TARGET: target_pos_q <= pwdata[POS_WIDTH-1:0];
					REG_VEL:    max_vel_q    <= pwdata[VEL_W-1:0];
					REG_ACCEL:  accel_q      <= pwdata[VEL_W-1:0];
					default:    ;
				endcase
			end

			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= cnt_load;
			end else if (!cnt_done) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			if (cnt_done) begin
				case (state_q)
					ST_IDLE: begin
						if (s_tvalid && s_tuser) begin
							elapsed_q <= '0;
							dist_q    <= dist_c;
							dir_neg_q <= dir_c;
						end
					end
					ST_DIV_T1: t1_q <= div_t48;
					ST_DIV_X1: begin
						tf_q   <= tf_trap;
						t2_q   <= tf_trap - t1_q;
						x1_q   <= quo_q[DIST_W-1:0];
						x2_q   <= dist_q - quo_q[DIST_W-1:0];
						peak_q <= ROOT_W'(v_eff);
					end
					ST_SQRT: peak_q <= root_q;
					ST_DIV_T1_TRI: begin
						t1_q <= div_t48;
						t2_q <= div_t48;
						tf_q <= tf_tri;
						x1_q <= dist_q >> 1;
						x2_q <= dist_q >> 1;
					end
					ST_ADVANCE: elapsed_q <= adv_t;
					default: ;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------
	// Serial engine and working registers.
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (!cnt_done) begin
			case (eng)
				ENG_MUL: begin
					acc_h_q <= mul_sum[WORD_W:1];
					acc_l_q <= {mul_sum[0], acc_l_q[WORD_W-1:1]};
				end
				ENG_DIV: begin
					rem_q <= div_ge ? div_diff[DVSR_W-1:0] : div_sh[DVSR_W-1:0];
					quo_q <= {quo_q[WORD_W-2:0], div_ge};
				end
				ENG_SQRT: begin
					srem_q <= sq_ge ? sq_diff[ROOT_W:0] : sq_r[ROOT_W:0];
					root_q <= {root_q[ROOT_W-2:0], sq_ge};
					src_q  <= {src_q[WORD_W-3:0], 2'b00};
				end
				default: ;
			endcase
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						tstep_q <= s_tdata[STEP_W-1:0];
						acc_h_q <= '0;
						mcand_q <= WORD_W'(dist_c);
						acc_l_q <= WORD_W'(a_eff);
					end
				end
				ST_MUL_DA: begin
					p1_q    <= mul_prod[WORD_W-1:0];
					acc_h_q <= '0;
					mcand_q <= WORD_W'(v_eff);
					acc_l_q <= WORD_W'(v_eff);
				end
				ST_MUL_VV: begin
					p2_q   <= mul_prod[WORD_W-1:0];
					rem_q  <= '0;
					quo_q  <= WORD_W'(v_eff) << FRAC_BITS;
					dvsr_q <= DVSR_W'(a_eff);
					src_q  <= p1_q;
					srem_q <= '0;
					root_q <= '0;
				end
				ST_DIV_T1: begin
					rem_q  <= '0;
					quo_q  <= WORD_W'(dist_q) << FRAC_BITS;
					dvsr_q <= DVSR_W'(v_eff);
				end
				ST_DIV_CRUISE: begin
					cruise_q <= div_t48;
					rem_q    <= '0;
					quo_q    <= p2_q;
					dvsr_q   <= {a_eff, 1'b0};
				end
				ST_SQRT: begin
					rem_q  <= '0;
					quo_q  <= WORD_W'(root_q) << FRAC_BITS;
					dvsr_q <= DVSR_W'(a_eff);
				end
				ST_CLASSIFY: begin
					ph_q    <= cls_phase;
					acc_h_q <= '0;
					case (cls_phase)
						PH_ACCEL: begin
							mcand_q <= WORD_W'(a_eff);
							acc_l_q <= WORD_W'(elapsed_q);
							t_op_q  <= elapsed_q;
						end
						PH_CRUISE: begin
							mcand_q <= WORD_W'(peak_q);
							acc_l_q <= WORD_W'(elapsed_q - t1_q);
						end
						PH_DECEL: begin
							mcand_q <= WORD_W'(peak_q);
							acc_l_q <= WORD_W'(elapsed_q - t2_q);
							t_op_q  <= elapsed_q - t2_q;
						end
						default: x_q <= dist_q;
					endcase
				end
				ST_MUL_GAIN: begin
					gain_q  <= gain_m;
					x_q     <= x_cruise;
					acc_h_q <= '0;
					mcand_q <= WORD_W'(a_eff);
					acc_l_q <= WORD_W'(t_op_q);
				end
				ST_MUL_A1: begin
					acc_h_q <= '0;
					mcand_q <= a1_m;
					acc_l_q <= WORD_W'(t_op_q);
				end
				ST_MUL_A2: begin
					x_q <= (ph_q == PH_ACCEL) ? x_accel : x_decel;
				end
				ST_POSN: begin
					if (out_free) begin
						out_pos_q <= pos_c;
						out_ph_q  <= ph_q;
						out_tt_q  <= tf_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({out_tt_q, out_ph_q, out_pos_q});

endmodule

`default_nettype wire
